/* design/assert_macros.svh */
// Shared assertion macros for the design folder.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/fib_pkg.sv */
package fib_pkg;

    localparam int OFFSET_BITS   = 40;
    localparam int LINE_BITS     = 31;
    localparam int NAME_LEN_BITS = 16;

    // Width for adding a line count to the running total without overflow.
    localparam int SUM_BITS = ((OFFSET_BITS > LINE_BITS) ? OFFSET_BITS : LINE_BITS) + 1;
    // Width for comparing a name span with the name length limit.
    localparam int SPAN_BITS = (OFFSET_BITS > NAME_LEN_BITS) ? OFFSET_BITS : NAME_LEN_BITS;

    localparam logic [OFFSET_BITS-1:0]   OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]     LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [NAME_LEN_BITS-1:0] NAME_MAX = {NAME_LEN_BITS{1'b1}};

    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0]   name_offset;
        logic [NAME_LEN_BITS-1:0] name_length;
        logic [OFFSET_BITS-1:0]   sequence_length;
        logic                     has_sequence;
        logic [OFFSET_BITS-1:0]   sequence_offset;
        logic [LINE_BITS-1:0]     line_bases;
        logic [LINE_BITS-1:0]     line_width;
    } t_out_item;

endpackage

/* design/fasta_index_builder.sv */
// Channel | Direction | Handshake               | Payload
// in      | into      | i_in_valid / o_in_stall | i_in_data  (t_in_item: byte, end mark)
// out     | out of    | o_out_valid / i_out_stall | o_out_data (t_out_item: index record)
//
// One byte is taken per cycle while o_in_stall is low; each byte is registered in the input
// register; its record, if any, is registered in the output register as the byte advances.
// The combinational scan update sustains one byte per cycle unless a record is stalled.
// Reset (synchronous, active low) clears the scan state and both valid flags.
// A stalled record holds the output register; bytes that produce no record keep
// flowing, and a record-producing byte waits in the input register until the slot frees.
`include "assert_macros.svh"

module fasta_index_builder
    import fib_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Input register.
    logic     r_in_valid;
    t_in_item r_in;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Stream position and current line.
    logic [OFFSET_BITS-1:0] r_byte_pos,  n_byte_pos;
    logic                   r_line_start, n_line_start;
    logic                   r_line_hdr,  n_line_hdr;
    logic [OFFSET_BITS-1:0] r_line_pos,  n_line_pos;
    logic [LINE_BITS-1:0]   r_line_bases, n_line_bases;
    logic [LINE_BITS-1:0]   r_line_bytes, n_line_bytes;

    // Open record.
    logic                   r_rec_open,   n_rec_open;
    logic                   r_name_begun, n_name_begun;
    logic                   r_name_closed, n_name_closed;
    logic                   r_name_cut,   n_name_cut;
    logic [OFFSET_BITS-1:0] r_name_start, n_name_start;
    logic [OFFSET_BITS-1:0] r_name_last,  n_name_last;
    logic [OFFSET_BITS-1:0] r_name_space, n_name_space;
    logic [OFFSET_BITS-1:0] r_total,      n_total;
    logic                   r_fl_seen,    n_fl_seen;
    logic [OFFSET_BITS-1:0] r_fl_offset,  n_fl_offset;
    logic [LINE_BITS-1:0]   r_fl_bases,   n_fl_bases;
    logic [LINE_BITS-1:0]   r_fl_width,   n_fl_width;

    logic      emit_open;
    logic      emit_eos;
    logic      emit;
    logic      advance;
    logic      in_xfer;
    t_out_item n_out;

    logic [7:0]             cur_byte;
    logic                   cur_eos;
    logic                   is_lf;
    logic                   opening;
    logic [SUM_BITS-1:0]    sum;
    logic                   src_cut;
    logic [OFFSET_BITS-1:0] src_start;
    logic [OFFSET_BITS-1:0] src_last;
    logic [OFFSET_BITS-1:0] src_space;
    logic [OFFSET_BITS-1:0] name_end;
    logic [SPAN_BITS-1:0]   name_span;

    function automatic logic f_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // Space, tab, LF, VT, FF and CR are not bases.
    function automatic logic f_space(input logic [7:0] b);
        return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    assign cur_byte = r_in.data_byte;
    assign cur_eos  = r_in.end_of_stream;
    assign is_lf    = (cur_byte == CH_LF);

    // Scan update for the byte in the input register.
    always_comb begin
        n_byte_pos    = r_byte_pos;
        n_line_start  = r_line_start;
        n_line_hdr    = r_line_hdr;
        n_line_pos    = r_line_pos;
        n_line_bases  = r_line_bases;
        n_line_bytes  = r_line_bytes;
        n_rec_open    = r_rec_open;
        n_name_begun  = r_name_begun;
        n_name_closed = r_name_closed;
        n_name_cut    = r_name_cut;
        n_name_start  = r_name_start;
        n_name_last   = r_name_last;
        n_name_space  = r_name_space;
        n_total       = r_total;
        n_fl_seen     = r_fl_seen;
        n_fl_offset   = r_fl_offset;
        n_fl_bases    = r_fl_bases;
        n_fl_width    = r_fl_width;
        opening       = 1'b0;
        emit_open     = 1'b0;
        sum           = '0;

        // Open a new line; a header closes out the previous record.
        if (r_line_start) begin
            n_line_start = 1'b0;
            n_line_hdr   = (cur_byte == CH_GT);
            n_line_pos   = r_byte_pos;
            n_line_bases = '0;
            n_line_bytes = '0;
            if (n_line_hdr) begin
                opening       = 1'b1;
                emit_open     = r_rec_open;
                n_rec_open    = 1'b0;
                n_name_begun  = 1'b0;
                n_name_closed = 1'b0;
                n_name_cut    = 1'b0;
                n_name_start  = '0;
                n_name_last   = '0;
                n_name_space  = '0;
                n_total       = '0;
                n_fl_seen     = 1'b0;
                n_fl_offset   = '0;
                n_fl_bases    = '0;
                n_fl_width    = '0;
            end
        end

        if (n_line_hdr) begin
            // Track the name span on the header line.
            if (!opening && !is_lf) begin
                if (!n_name_begun) begin
                    if (!f_blank(cur_byte)) begin
                        n_name_begun = 1'b1;
                        n_name_start = r_byte_pos;
                        n_name_last  = r_byte_pos;
                    end
                end else if (!n_name_closed) begin
                    if (cur_byte == CH_SP) begin
                        n_name_closed = 1'b1;
                        n_name_space  = r_byte_pos;
                    end else if (!f_blank(cur_byte)) begin
                        n_name_last = r_byte_pos;
                    end
                end else if (!f_blank(cur_byte)) begin
                    n_name_cut = 1'b1;
                end
            end
        end else begin
            if (n_line_bytes != LINE_MAX) begin
                n_line_bytes = n_line_bytes + 1'b1;
            end
            if (!f_space(cur_byte) && (n_line_bases != LINE_MAX)) begin
                n_line_bases = n_line_bases + 1'b1;
            end
        end

        // Close the line.
        if (is_lf || cur_eos) begin
            if (n_line_hdr) begin
                n_rec_open = n_name_begun;
            end else if (n_rec_open && (n_line_bases != '0)) begin
                sum = SUM_BITS'(n_total) + SUM_BITS'(n_line_bases);
                n_total = (sum > SUM_BITS'(OFF_MAX)) ? OFF_MAX : sum[OFFSET_BITS-1:0];
                if (!n_fl_seen) begin
                    n_fl_seen   = 1'b1;
                    n_fl_offset = n_line_pos;
                    n_fl_bases  = n_line_bases;
                    n_fl_width  = is_lf ? n_line_bytes : n_line_bases;
                end
            end
            n_line_start = 1'b1;
        end

        if (r_byte_pos != OFF_MAX) begin
            n_byte_pos = r_byte_pos + 1'b1;
        end

        emit_eos = cur_eos && n_rec_open;

        // A header emits the record as it stood; stream end emits it as updated.
        src_cut   = emit_open ? r_name_cut   : n_name_cut;
        src_start = emit_open ? r_name_start : n_name_start;
        src_last  = emit_open ? r_name_last  : n_name_last;
        src_space = emit_open ? r_name_space : n_name_space;

        name_end = src_last;
        if (src_cut && (src_space != '0)) begin
            name_end = src_space - 1'b1;
        end
        if (name_end < src_start) begin
            name_end = src_start;
        end
        name_span = SPAN_BITS'(name_end - src_start);

        n_out.name_offset = src_start;
        n_out.name_length = (name_span >= SPAN_BITS'(NAME_MAX)) ? NAME_MAX
                          : NAME_LEN_BITS'(name_span + 1'b1);
        if (emit_open) begin
            n_out.sequence_length = r_total;
            n_out.has_sequence    = r_fl_seen;
            n_out.sequence_offset = r_fl_offset;
            n_out.line_bases      = r_fl_bases;
            n_out.line_width      = r_fl_width;
        end else begin
            n_out.sequence_length = n_total;
            n_out.has_sequence    = n_fl_seen;
            n_out.sequence_offset = n_fl_offset;
            n_out.line_bases      = n_fl_bases;
            n_out.line_width      = n_fl_width;
        end

        // Stream end: return everything to its reset state.
        if (cur_eos) begin
            n_byte_pos    = '0;
            n_line_start  = 1'b1;
            n_line_hdr    = 1'b0;
            n_line_pos    = '0;
            n_line_bases  = '0;
            n_line_bytes  = '0;
            n_rec_open    = 1'b0;
            n_name_begun  = 1'b0;
            n_name_closed = 1'b0;
            n_name_cut    = 1'b0;
            n_name_start  = '0;
            n_name_last   = '0;
            n_name_space  = '0;
            n_total       = '0;
            n_fl_seen     = 1'b0;
            n_fl_offset   = '0;
            n_fl_bases    = '0;
            n_fl_width    = '0;
        end
    end

    assign emit = emit_open || emit_eos;

    // Advance the byte unless it carries a record and the output slot stays full.
    assign advance    = r_in_valid && (!emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_byte_pos    <= '0;
            r_line_start  <= 1'b1;
            r_line_hdr    <= 1'b0;
            r_line_pos    <= '0;
            r_line_bases  <= '0;
            r_line_bytes  <= '0;
            r_rec_open    <= 1'b0;
            r_name_begun  <= 1'b0;
            r_name_closed <= 1'b0;
            r_name_cut    <= 1'b0;
            r_name_start  <= '0;
            r_name_last   <= '0;
            r_name_space  <= '0;
            r_total       <= '0;
            r_fl_seen     <= 1'b0;
            r_fl_offset   <= '0;
            r_fl_bases    <= '0;
            r_fl_width    <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_byte_pos    <= n_byte_pos;
                r_line_start  <= n_line_start;
                r_line_hdr    <= n_line_hdr;
                r_line_pos    <= n_line_pos;
                r_line_bases  <= n_line_bases;
                r_line_bytes  <= n_line_bytes;
                r_rec_open    <= n_rec_open;
                r_name_begun  <= n_name_begun;
                r_name_closed <= n_name_closed;
                r_name_cut    <= n_name_cut;
                r_name_start  <= n_name_start;
                r_name_last   <= n_name_last;
                r_name_space  <= n_name_space;
                r_total       <= n_total;
                r_fl_seen     <= n_fl_seen;
                r_fl_offset   <= n_fl_offset;
                r_fl_bases    <= n_fl_bases;
                r_fl_width    <= n_fl_width;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMPLIES(a_closed_needs_begun, r_name_closed, r_name_begun)
    `ASSERT_IMPLIES(a_first_line_in_record, r_fl_seen, r_rec_open)
    `ASSERT_NEXT(a_eos_resets, advance && cur_eos,
        (r_byte_pos == '0) && r_line_start && !r_rec_open)
    `ASSERT_IMPLIES(a_result_from_byte, $rose(r_out_valid), $past(advance && emit))

endmodule

/* verif/tb_fasta_index_builder.sv */
module tb_fasta_index_builder;
    timeunit 1ns;
    timeprecision 1ps;

    import fib_pkg::*;

    localparam int          CLK_PERIOD   = 2;
    localparam int          TARGET_ITEMS = 1250;
    // Long receiver hold-off: enough to back up the output and input registers.
    localparam int          LONG_HOLD    = 400;
    localparam int          HOLD_AT      = 300;
    localparam int          PAUSE_AT     = 650;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          SETTLE       = 8;
    localparam logic [7:0]  CH_VT        = 8'h0B;
    localparam logic [7:0]  CH_FF        = 8'h0C;

    // ------------------------------------------------------------------
    // Scoreboard: runs its own copy of the scan state, predicts the index
    // record each accepted byte causes, and checks records as they leave.
    // ------------------------------------------------------------------
    class fasta_index_tracker;
        t_out_item                expected_records[$];
        int unsigned              mismatches;

        logic [OFFSET_BITS-1:0]   stream_pos;
        bit                       line_fresh;
        bit                       header_line;
        logic [OFFSET_BITS-1:0]   line_origin;
        logic [LINE_BITS-1:0]     line_base_cnt;
        logic [LINE_BITS-1:0]     line_byte_cnt;
        bit                       rec_open;
        bit                       name_started;
        bit                       name_ended;
        bit                       name_trimmed;
        logic [OFFSET_BITS-1:0]   name_first;
        logic [OFFSET_BITS-1:0]   name_last;
        logic [OFFSET_BITS-1:0]   name_space;
        logic [OFFSET_BITS-1:0]   base_total;
        bit                       first_seen;
        logic [OFFSET_BITS-1:0]   first_origin;
        logic [LINE_BITS-1:0]     first_bases;
        logic [LINE_BITS-1:0]     first_width;

        function new();
            mismatches = 0;
            restart_scan();
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void clear_record();
            rec_open     = 1'b0;
            name_started = 1'b0;
            name_ended   = 1'b0;
            name_trimmed = 1'b0;
            name_first   = '0;
            name_last    = '0;
            name_space   = '0;
            base_total   = '0;
            first_seen   = 1'b0;
            first_origin = '0;
            first_bases  = '0;
            first_width  = '0;
        endfunction

        function void restart_scan();
            stream_pos    = '0;
            line_fresh    = 1'b1;
            header_line   = 1'b0;
            line_origin   = '0;
            line_base_cnt = '0;
            line_byte_cnt = '0;
            clear_record();
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
        endfunction

        function bit is_space(logic [7:0] b);
            return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
        endfunction

        function void follow_name(logic [7:0] b, logic [OFFSET_BITS-1:0] pos);
            if (!name_started) begin
                if (!is_blank(b)) begin
                    name_started = 1'b1;
                    name_first   = pos;
                    name_last    = pos;
                end
            end else if (!name_ended) begin
                if (b == CH_SP) begin
                    name_ended = 1'b1;
                    name_space = pos;
                end else if (!is_blank(b)) begin
                    name_last = pos;
                end
            end else if (!is_blank(b)) begin
                // something follows the space: the name stops before it
                name_trimmed = 1'b1;
            end
        endfunction

        function void queue_record();
            t_out_item              rec;
            logic [OFFSET_BITS-1:0] name_end;
            logic [OFFSET_BITS-1:0] span;
            name_end = name_last;
            if (name_trimmed && name_space != 0)
                name_end = name_space - 1;
            if (name_end < name_first)
                name_end = name_first;
            span = name_end - name_first;
            rec.name_offset     = name_first;
            rec.name_length     = (span >= NAME_MAX) ? NAME_MAX : NAME_LEN_BITS'(span + 1);
            rec.sequence_length = base_total;
            rec.has_sequence    = first_seen;
            rec.sequence_offset = first_seen ? first_origin : '0;
            rec.line_bases      = first_seen ? first_bases : '0;
            rec.line_width      = first_seen ? first_width : '0;
            expected_records = {expected_records, rec};
        endfunction

        // Advance the scan by one accepted byte.
        function void note_byte(t_in_item it);
            logic [7:0]             b;
            logic [OFFSET_BITS-1:0] pos;
            logic [OFFSET_BITS:0]   sum;
            bit                     opening;
            bit                     lf;
            b       = it.data_byte;
            pos     = stream_pos;
            opening = 1'b0;
            lf      = (b == CH_LF);

            if (line_fresh) begin
                line_fresh    = 1'b0;
                header_line   = (b == CH_GT);
                line_origin   = pos;
                line_base_cnt = '0;
                line_byte_cnt = '0;
                if (header_line) begin
                    opening = 1'b1;
                    if (rec_open)
                        queue_record();
                    clear_record();
                end
            end

            if (header_line) begin
                if (!opening && !lf)
                    follow_name(b, pos);
            end else begin
                if (line_byte_cnt != LINE_MAX)
                    line_byte_cnt++;
                if (!is_space(b) && line_base_cnt != LINE_MAX)
                    line_base_cnt++;
            end

            if (lf || it.end_of_stream) begin
                if (header_line) begin
                    rec_open = name_started;
                end else if (rec_open && line_base_cnt != 0) begin
                    sum = {1'b0, base_total} + line_base_cnt;
                    base_total = (sum > OFF_MAX) ? OFF_MAX : sum[OFFSET_BITS-1:0];
                    if (!first_seen) begin
                        first_seen   = 1'b1;
                        first_origin = line_origin;
                        first_bases  = line_base_cnt;
                        first_width  = lf ? line_byte_cnt : line_base_cnt;
                    end
                end
                line_fresh = 1'b1;
            end

            if (stream_pos != OFF_MAX)
                stream_pos++;

            if (it.end_of_stream) begin
                if (rec_open)
                    queue_record();
                restart_scan();
            end
        endfunction

        function bit field_ok(string field, logic [63:0] want, logic [63:0] got);
            if (want === got)
                return 1'b1;
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1'b0;
        endfunction

        function void check_record(t_out_item got);
            t_out_item want;
            bit        ok;
            if (expected_records.size() == 0) begin
                $error("index record arrived with none expected (name_offset %0d)",
                       got.name_offset);
                mismatches++;
                return;
            end
            want = expected_records.pop_front();
            ok = 1'b1;
            ok = field_ok("name_offset", want.name_offset, got.name_offset) & ok;
            ok = field_ok("name_length", want.name_length, got.name_length) & ok;
            ok = field_ok("sequence_length", want.sequence_length, got.sequence_length) & ok;
            ok = field_ok("has_sequence", want.has_sequence, got.has_sequence) & ok;
            ok = field_ok("sequence_offset", want.sequence_offset, got.sequence_offset) & ok;
            ok = field_ok("line_bases", want.line_bases, got.line_bases) & ok;
            ok = field_ok("line_width", want.line_width, got.line_width) & ok;
            if (!ok)
                mismatches++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    fasta_index_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    fasta_index_tracker tracker = new();

    // Byte stream to send, built up front: directed bytes first, then random streams.
    t_in_item byte_q[$];

    // Idle controls set by the main sequence for the driver and the receiver.
    bit tx_busy  = 1'b0;
    bit rx_busy  = 1'b0;
    bit hold_req = 1'b0;

    // ------------------------------------------------------------------
    // Stream construction
    // ------------------------------------------------------------------
    function automatic void put(logic [7:0] b);
        t_in_item it;
        it.data_byte     = b;
        it.end_of_stream = 1'b0;
        byte_q = {byte_q, it};
    endfunction

    // Flag the last queued byte as the end of its stream.
    function automatic void mark_end();
        t_in_item it;
        int       last;
        last = byte_q.size() - 1;
        it = byte_q[last];
        it.end_of_stream = 1'b1;
        byte_q[last] = it;
    endfunction

    function automatic void put_text(string s, bit last_ends);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
        if (last_ends)
            mark_end();
    endfunction

    function automatic logic [7:0] pick_base();
        string       alphabet = "ACGTNacgtnRYKM";
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return alphabet[$urandom_range(0, alphabet.len() - 1)];
        case (r)
            15:      return CH_SP;
            16:      return CH_VT;
            17:      return CH_FF;
            18:      return CH_TAB;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        logic [7:0] b;
        if ($urandom_range(0, 7) != 0)
            return 8'($urandom_range(8'h21, 8'h7E));
        // any byte but a newline: tabs, CRs and spaces inside the name matter
        b = 8'($urandom_range(0, 255));
        return (b == CH_LF) ? CH_GT : b;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SP;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void gen_header();
        int n;
        put(CH_GT);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put(pick_blank());
        if ($urandom_range(0, 7) == 0) begin
            // empty name: closes the previous record, opens none
            if ($urandom_range(0, 1) != 0)
                put(CH_SP);
            put(CH_LF);
            return;
        end
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        repeat (n) put(pick_name_char());
        case ($urandom_range(0, 2))
            0: ;
            1: begin
                put(CH_SP);
                repeat ($urandom_range(1, 10)) put(8'($urandom_range(8'h20, 8'h7E)));
            end
            default: begin
                repeat ($urandom_range(1, 2))
                    put(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
            end
        endcase
        if ($urandom_range(0, 2) == 0)
            put(CH_CR);
        put(CH_LF);
    endfunction

    function automatic void gen_sequence();
        int width;
        int lines;
        int cnt;
        width = $urandom_range(1, 16);
        lines = $urandom_range(0, 5);
        for (int l = 0; l < lines; l++) begin
            if ($urandom_range(0, 9) == 0) begin
                // blank or whitespace-only line
                if ($urandom_range(0, 1) != 0)
                    put(CH_SP);
            end else begin
                cnt = (l == lines - 1) ? $urandom_range(1, width) : width;
                repeat (cnt) put(pick_base());
                if ($urandom_range(0, 3) == 0)
                    put(CH_CR);
            end
            put(CH_LF);
        end
    endfunction

    function automatic void gen_stream();
        t_in_item tail;
        if ($urandom_range(0, 4) == 0) begin
            // junk ahead of the first header
            repeat ($urandom_range(1, 6)) put(pick_base());
            put(CH_LF);
        end
        repeat ($urandom_range(1, 4)) begin
            gen_header();
            gen_sequence();
        end
        case ($urandom_range(0, 4))
            0, 1: mark_end();
            2: begin
                // last line left without its newline
                tail = byte_q[$];
                if (tail.data_byte == CH_LF)
                    byte_q.delete(byte_q.size() - 1);
                mark_end();
            end
            3: begin
                put(CH_GT);
                mark_end();
            end
            default: begin
                put(CH_GT);
                repeat ($urandom_range(1, 3)) put(pick_name_char());
                mark_end();
            end
        endcase
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(5, 40)) begin
            case ($urandom_range(0, 5))
                0:       put(CH_LF);
                1:       put(CH_GT);
                default: put(8'($urandom_range(0, 255)));
            endcase
        end
        mark_end();
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    // Offer one byte, with an optional idle burst ahead of it, and hold it
    // until the transfer completes.
    task automatic send_byte(t_in_item it);
        int gap;
        gap = (tx_busy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
        tracker.note_byte(it);
    endtask

    // Drop valid and wait for every predicted record to come out.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        stall_left  = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (rx_busy && $urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    // Check every record transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && !i_out_stall)
            tracker.check_record(o_out_data);
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #400us;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int quiet_from;
        int waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // Directed bytes:
        //   junk before any header, a header with an empty name, a name with a
        //   leading blank, an inner tab and a trailing word cut at the space,
        //   a CRLF base line, an unterminated final line, end of stream on the
        //   header marker itself, a record with no sequence, and a lone byte
        //   that ends a stream holding no record.
        put_text("z\n>\n> a\tb c\015\nAC\015\nGT", 1'b1);
        put_text(">", 1'b1);
        put_text(">q", 1'b1);
        put(8'hFF);
        mark_end();

        // Random part: mostly well-formed FASTA, some raw noise streams.
        while (byte_q.size() < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                gen_noise();
            else
                gen_stream();
        end
        quiet_from = (byte_q.size() * 85) / 100;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < byte_q.size(); i++) begin
            // Reshuffle idling every hundred bytes; some stretches run flat out.
            if (i % 100 == 0) begin
                tx_busy = ($urandom_range(0, 2) != 0);
                rx_busy = ($urandom_range(0, 2) != 0);
            end
            // Run the tail with no idling on either side.
            if (i >= quiet_from) begin
                tx_busy = 1'b0;
                rx_busy = 1'b0;
            end
            // Long receiver hold-off while bytes keep coming: backs up the input.
            if (i == HOLD_AT)
                hold_req = 1'b1;
            // Pause the sender until the output side is empty.
            if (i == PAUSE_AT)
                wait_for_drain();
            send_byte(byte_q[i]);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Wait for outstanding records, then let any stray output settle out.
        waited = 0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);

        if (tracker.pending() != 0)
            $error("%0d expected index records never arrived", tracker.pending());

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
